>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define LFE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfe assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define LFE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfe assertion failed");

`endif

>>> hdl/lfe_pkg.sv
// ----------------------------------------------------------------------------
// lfe_pkg
// Shared constants and types for the toroidal life automaton.
// ----------------------------------------------------------------------------
package lfe_pkg;

  parameter int COLS  = 64;
  parameter int ROWS  = 32;
  parameter int COL_W = 6;
  parameter int ROW_W = 5;
  parameter int GEN_W = 32;
  parameter int CNT_W = $clog2(ROWS + 3);

  // Neighbor counts of the B3/S23 rule.
  parameter logic [3:0] NBR_KEEP  = 4'd2;
  parameter logic [3:0] NBR_BIRTH = 4'd3;

  // Opcodes.
  parameter logic [1:0] OP_WRITE = 2'd0;
  parameter logic [1:0] OP_READ  = 2'd1;
  parameter logic [1:0] OP_CLEAR = 2'd2;
  parameter logic [1:0] OP_STEP  = 2'd3;

  // Sweep counter marks.
  parameter logic [CNT_W-1:0] SWEEP_FIRST_WR = CNT_W'(3);
  parameter logic [CNT_W-1:0] SWEEP_ROW0     = CNT_W'(2);
  parameter logic [CNT_W-1:0] SWEEP_LAST     = CNT_W'(ROWS + 2);

  typedef logic [COLS-1:0] row_t;

endpackage

>>> hdl/lfe_ram.sv
// ----------------------------------------------------------------------------
// lfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/lfe_row_unit.sv
// ----------------------------------------------------------------------------
// lfe_row_unit
// Row-wide B3/S23 update of one row from the rows above and below.
// ----------------------------------------------------------------------------
module lfe_row_unit (
  input  lfe_pkg::row_t up,
  input  lfe_pkg::row_t mid,
  input  lfe_pkg::row_t down,
  output lfe_pkg::row_t next_row
);

  for (genvar c = 0; c < lfe_pkg::COLS; c++) begin : g_cell
    // Columns wrap around at both edges.
    localparam int L = (c == 0) ? lfe_pkg::COLS - 1 : c - 1;
    localparam int R = (c == lfe_pkg::COLS - 1) ? 0 : c + 1;
    logic [3:0] n;

    assign n = {3'b0, up[L]}   + {3'b0, up[c]}   + {3'b0, up[R]}
             + {3'b0, mid[L]}                    + {3'b0, mid[R]}
             + {3'b0, down[L]} + {3'b0, down[c]} + {3'b0, down[R]};
    assign next_row[c] = (n == lfe_pkg::NBR_BIRTH) | (mid[c] & (n == lfe_pkg::NBR_KEEP));
  end

endmodule

>>> hdl/life_automaton_torus_step_top.sv
// ----------------------------------------------------------------------------
// life_automaton_torus_step_top
// Life automaton (B3/S23) on a wrapping grid of ROWS x COLS one-bit cells.
// ----------------------------------------------------------------------------
// Each accepted command gives a done strobe: a clear answers in the cycle
// after it is taken; a read or write passes through FETCH and APPLY first.
// Busy stays high over FETCH and APPLY, or over SWEEP for a step;
// a sweep reads one row from the RAM per cycle, feeding the single row unit.
// Every beat gives exactly one done strobe; the receiver cannot stall it.
// Synchronous reset: all cells read as dead, generation is zero, block idle.
// ----------------------------------------------------------------------------
module life_automaton_torus_step_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode,
  input  logic [lfe_pkg::COL_W-1:0]  col,
  input  logic [lfe_pkg::ROW_W-1:0]  row,
  input  logic                       value,
  output logic                       done,
  output logic                       cell_value,
  output logic [lfe_pkg::GEN_W-1:0]  generation
);

  // Sequencer states. FETCH reads the addressed row, APPLY uses the read data,
  // SWEEP runs a whole generation one row per cycle.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [1:0]                  state;
  logic [lfe_pkg::CNT_W-1:0]   cnt;
  logic [1:0]                  op_q;
  logic [lfe_pkg::COL_W-1:0]   col_q;
  logic [lfe_pkg::ROW_W-1:0]   row_q;
  logic                        value_q;

  // One valid bit per row: a row never written since reset or clear reads as
  // all dead, so clear needs no pass over the RAM.
  logic [lfe_pkg::ROWS-1:0]    row_valid;
  logic                        rd_valid;

  // Sliding window of old rows during a sweep, plus the old row 0, which is
  // overwritten early but is the lower neighbor of the last row.
  lfe_pkg::row_t               prev_row;
  lfe_pkg::row_t               cur_row;
  lfe_pkg::row_t               row0_save;
  logic                        cap_bit;

  lfe_pkg::row_t               ram_rdata;
  lfe_pkg::row_t               rd_row;
  lfe_pkg::row_t               mod_row;
  lfe_pkg::row_t               down_row;
  lfe_pkg::row_t               new_row;
  lfe_pkg::row_t               wdata;
  logic                        we;
  logic [lfe_pkg::ROW_W-1:0]   waddr;
  logic [lfe_pkg::ROW_W-1:0]   raddr;
  logic [lfe_pkg::CNT_W-1:0]   cnt_m1;
  logic [lfe_pkg::CNT_W-1:0]   cnt_m3;
  logic                        inside_q;
  logic                        sweep_wr;
  logic                        accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // With the field widths at full grid size this is always true; it guards
  // smaller grids against addresses past the edge.
  assign inside_q = (int'(col_q) < lfe_pkg::COLS) && (int'(row_q) < lfe_pkg::ROWS);

  assign rd_row = rd_valid ? ram_rdata : '0;

  // Sweep schedule: at count k the RAM reads row ROWS-1 when k is 0 and row
  // k-1 after that; from count 3 on it writes the new row k-3, whose lower
  // neighbor is the data arriving then (or the saved row 0 for the last row).
  assign cnt_m1   = cnt - lfe_pkg::CNT_W'(1);
  assign cnt_m3   = cnt - lfe_pkg::SWEEP_FIRST_WR;
  assign sweep_wr = (state == ST_SWEEP) && (cnt >= lfe_pkg::SWEEP_FIRST_WR);
  assign down_row = (cnt == lfe_pkg::SWEEP_LAST) ? row0_save : rd_row;

  always_comb begin
    if (state == ST_SWEEP) begin
      raddr = (cnt == '0) ? lfe_pkg::ROW_W'(lfe_pkg::ROWS - 1) : cnt_m1[lfe_pkg::ROW_W-1:0];
    end else begin
      raddr = row_q;
    end
  end

  always_comb begin
    mod_row        = rd_row;
    mod_row[col_q] = value_q;
  end

  always_comb begin
    if (state == ST_SWEEP) begin
      we    = sweep_wr;
      waddr = cnt_m3[lfe_pkg::ROW_W-1:0];
      wdata = new_row;
    end else begin
      we    = (state == ST_APPLY) && (op_q == lfe_pkg::OP_WRITE) && inside_q;
      waddr = row_q;
      wdata = mod_row;
    end
  end

  lfe_ram #(
    .WIDTH(lfe_pkg::COLS),
    .DEPTH(lfe_pkg::ROWS)
  ) u_grid (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  lfe_row_unit u_rule (
    .up      (prev_row),
    .mid     (cur_row),
    .down    (down_row),
    .next_row(new_row)
  );

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    rd_valid <= row_valid[raddr];
    if (accept) begin
      op_q    <= opcode;
      col_q   <= col;
      row_q   <= row;
      value_q <= value;
    end
    if (state == ST_SWEEP && cnt != '0) begin
      prev_row <= cur_row;
      cur_row  <= rd_row;
      if (cnt == lfe_pkg::SWEEP_ROW0) begin
        row0_save <= rd_row;
      end
    end
    if (sweep_wr && waddr == row_q) begin
      cap_bit <= new_row[col_q];
    end
  end

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      row_valid  <= '0;
      done       <= 1'b0;
      cell_value <= 1'b0;
      generation <= '0;
    end else begin
      done <= 1'b0;
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (opcode)
              lfe_pkg::OP_CLEAR: begin
                row_valid  <= '0;
                generation <= '0;
                cell_value <= 1'b0;
                done       <= 1'b1;
              end
              lfe_pkg::OP_STEP: begin
                cnt   <= '0;
                state <= ST_SWEEP;
              end
              default: begin
                state <= ST_FETCH;
              end
            endcase
          end
        end
        ST_FETCH: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          // A write reports the value it stored; a read reports the cell.
          if (op_q == lfe_pkg::OP_WRITE) begin
            cell_value <= inside_q & value_q;
          end else begin
            cell_value <= inside_q & rd_row[col_q];
          end
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_SWEEP: begin
          cnt <= cnt + lfe_pkg::CNT_W'(1);
          if (cnt == lfe_pkg::SWEEP_LAST) begin
            // The last row is written now; take its bit directly if addressed.
            cell_value <= inside_q & ((waddr == row_q) ? new_row[col_q] : cap_bit);
            generation <= generation + lfe_pkg::GEN_W'(1);
            done       <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/lfe_checker.sv
// ----------------------------------------------------------------------------
// lfe_checker
// Port-level checks of the life automaton, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfe_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 opcode,
  input logic                       done,
  input logic                       cell_value,
  input logic [lfe_pkg::GEN_W-1:0]  generation
);

  // A clear answers in the next cycle with a dead cell and a zero count.
  `LFE_ASSERT_NXT(a_clear_result, start && !busy && opcode == lfe_pkg::OP_CLEAR, done && generation == '0 && !cell_value)

  // Every other opcode keeps the block busy after it is taken.
  `LFE_ASSERT_NXT(a_busy_after_start, start && !busy && opcode != lfe_pkg::OP_CLEAR, busy)

  // Reads and writes answer after passing through FETCH and APPLY.
  `LFE_ASSERT_IMP(a_rw_latency, start && !busy && (opcode == lfe_pkg::OP_WRITE || opcode == lfe_pkg::OP_READ), ##3 done)

  // A result is shown only while the block is idle.
  `LFE_ASSERT_IMP(a_done_idle, done, !busy)

  // The generation count moves only together with a result.
  `LFE_ASSERT_IMP(a_gen_stable, !done && !$past(rst), $stable(generation))

endmodule

bind life_automaton_torus_step_top lfe_checker u_lfe_checker (.*);

>>> dv/life_automaton_torus_step_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_torus_step_top_tb
// Self-checking bench for the wrapping B3/S23 life grid. A bit-level board
// model predicts cell and generation for every accepted command beat, and a
// monitor compares each done strobe against the oldest prediction in order.
// ----------------------------------------------------------------------------
module life_automaton_torus_step_top_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BEATS = 900;
  // The last stretch of the random traffic runs back to back, with no gaps.
  localparam int unsigned CALM_TAIL    = 150;
  // A step is the slowest command; leave a bit of margin.
  localparam int unsigned DRAIN_CYCLES = lfe_pkg::ROWS + 16;

  // One predicted result beat: addressed cell and generation count.
  typedef struct packed {
    logic                      cell_bit;
    logic [lfe_pkg::GEN_W-1:0] gen;
  } readback_t;

  logic                      clk    = 1'b0;
  logic                      rst    = 1'b1;
  logic                      start  = 1'b0;
  logic [1:0]                opcode = lfe_pkg::OP_READ;
  logic [lfe_pkg::COL_W-1:0] col    = '0;
  logic [lfe_pkg::ROW_W-1:0] row    = '0;
  logic                      value  = 1'b0;
  logic                      busy;
  logic                      done;
  logic                      cell_value;
  logic [lfe_pkg::GEN_W-1:0] generation;

  // Board model: bit c of board[r] is the cell at column c, row r.
  lfe_pkg::row_t             board [lfe_pkg::ROWS];
  logic [lfe_pkg::GEN_W-1:0] gen_count = '0;
  readback_t                 readback_q [$];

  int unsigned beats_sent  = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          idle_on     = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  life_automaton_torus_step_top uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .col        (col),
    .row        (row),
    .value      (value),
    .done       (done),
    .cell_value (cell_value),
    .generation (generation)
  );

  initial begin
    foreach (board[i]) board[i] = '0;
  end

  // --------------------------------------------------------------------------
  // Board model
  // --------------------------------------------------------------------------

  // Cell lookup with wrap on both axes; callers pass non-negative offsets.
  function automatic logic cell_at(int unsigned c, int unsigned r);
    return board[r % lfe_pkg::ROWS][c % lfe_pkg::COLS];
  endfunction

  // One generation of B3/S23. Every cell is computed from the old board
  // before any of them is replaced.
  task automatic evolve_board();
    lfe_pkg::row_t next_board [lfe_pkg::ROWS];
    int unsigned   n;
    logic          alive;
    for (int unsigned r = 0; r < lfe_pkg::ROWS; r++) begin
      for (int unsigned c = 0; c < lfe_pkg::COLS; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              n += cell_at(c + lfe_pkg::COLS + dc, r + lfe_pkg::ROWS + dr);
            end
          end
        end
        alive = board[r][c];
        next_board[r][c] = (alive && (n == lfe_pkg::NBR_KEEP || n == lfe_pkg::NBR_BIRTH)) ||
                           (!alive && n == lfe_pkg::NBR_BIRTH);
      end
    end
    board = next_board;
    gen_count = gen_count + lfe_pkg::GEN_W'(1);
  endtask

  // Applies one accepted command to the board and queues its result beat.
  task automatic apply_command(input logic [1:0] op, input int unsigned c,
                               input int unsigned r, input logic v);
    bit        on_grid;
    readback_t rb;
    // With the grid filling the whole address space this always holds; the
    // guard keeps the model honest if the grid is ever made smaller.
    on_grid = (c < lfe_pkg::COLS) && (r < lfe_pkg::ROWS);
    case (op)
      lfe_pkg::OP_WRITE: begin
        if (on_grid) board[r][c] = v;
      end
      lfe_pkg::OP_CLEAR: begin
        foreach (board[i]) board[i] = '0;
        gen_count = '0;
      end
      lfe_pkg::OP_STEP: begin
        evolve_board();
      end
      default: begin
      end
    endcase
    rb.cell_bit = on_grid ? board[r][c] : 1'b0;
    rb.gen      = gen_count;
    readback_q.push_back(rb);
  endtask

  // --------------------------------------------------------------------------
  // Command driver
  // --------------------------------------------------------------------------

  // Presents one command beat and returns at the edge that accepts it. Start
  // is left high so that a beat sent right after goes out with no bubble; a
  // random gap lowers it first, and only at a step where nothing raised it.
  task automatic send_beat(input logic [1:0] op, input logic [lfe_pkg::COL_W-1:0] c,
                           input logic [lfe_pkg::ROW_W-1:0] r, input logic v);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 3);
      // Half of the gaps begin once the block has gone idle, so that they
      // also land right at the end of a sweep, not only at its start. The
      // cycle seen idle there already counts toward the gap.
      if ($urandom_range(0, 1) == 1) begin
        @(posedge clk);
        while (busy) @(posedge clk);
        gap--;
      end
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    opcode <= op;
    col    <= c;
    row    <= r;
    value  <= v;
    // Busy is read right after the edge, so it is the value the block saw.
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_command(op, 32'(c), 32'(r), v);
    beats_sent++;
  endtask

  // Picks a coordinate inside a window that may wrap past the grid edge.
  function automatic int unsigned wrap_pick(int unsigned origin, int unsigned span,
                                            int unsigned size);
    return (origin + $urandom_range(0, span - 1)) % size;
  endfunction

  // Random field values at the port widths.
  function automatic logic [lfe_pkg::COL_W-1:0] rand_col();
    return lfe_pkg::COL_W'($urandom_range(0, lfe_pkg::COLS - 1));
  endfunction

  function automatic logic [lfe_pkg::ROW_W-1:0] rand_row();
    return lfe_pkg::ROW_W'($urandom_range(0, lfe_pkg::ROWS - 1));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // --------------------------------------------------------------------------
  // Result monitor: done is sampled at the edge that ends its cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_readback
    readback_t want;
    if (!rst && done) begin
      if (readback_q.size() == 0) begin
        fail_count++;
        $error("result beat with nothing pending: cell_value=%0d generation=%0d",
               cell_value, generation);
      end else begin
        want = readback_q.pop_front();
        if (cell_value !== want.cell_bit) begin
          fail_count++;
          $error("cell_value: expected %0d, actual %0d", want.cell_bit, cell_value);
        end
        if (generation !== want.gen) begin
          fail_count++;
          $error("generation: expected %0d, actual %0d", want.gen, generation);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // After reset every cell is dead and the counter is zero. A step on the
  // empty board leaves it empty but still moves the counter.
  task automatic test_reset_state();
    send_beat(lfe_pkg::OP_READ, '0, '0, 1'b0);
    send_beat(lfe_pkg::OP_READ, lfe_pkg::COL_W'(lfe_pkg::COLS - 1),
              lfe_pkg::ROW_W'(lfe_pkg::ROWS - 1), 1'b1);
    send_beat(lfe_pkg::OP_STEP, lfe_pkg::COL_W'(lfe_pkg::COLS / 2),
              lfe_pkg::ROW_W'(lfe_pkg::ROWS / 2), 1'b0);
  endtask

  // Writes and reads at the corner addresses, with both write values.
  task automatic test_write_read_extremes();
    send_beat(lfe_pkg::OP_WRITE, lfe_pkg::COL_W'(lfe_pkg::COLS - 1),
              lfe_pkg::ROW_W'(lfe_pkg::ROWS - 1), 1'b1);
    send_beat(lfe_pkg::OP_READ,  lfe_pkg::COL_W'(lfe_pkg::COLS - 1),
              lfe_pkg::ROW_W'(lfe_pkg::ROWS - 1), 1'b0);
    send_beat(lfe_pkg::OP_WRITE, '0, '0, 1'b1);
    send_beat(lfe_pkg::OP_READ,  '0, '0, 1'b1);
    send_beat(lfe_pkg::OP_WRITE, lfe_pkg::COL_W'(lfe_pkg::COLS - 1),
              lfe_pkg::ROW_W'(lfe_pkg::ROWS - 1), 1'b0);
    send_beat(lfe_pkg::OP_READ,  lfe_pkg::COL_W'(lfe_pkg::COLS - 1),
              lfe_pkg::ROW_W'(lfe_pkg::ROWS - 1), 1'b1);
    send_beat(lfe_pkg::OP_READ,  '0, lfe_pkg::ROW_W'(lfe_pkg::ROWS - 1), 1'b0);
  endtask

  // Clear addressed at a live cell must still return a dead cell, and it
  // takes the generation count back to zero.
  task automatic test_clear();
    send_beat(lfe_pkg::OP_CLEAR, '0, '0, 1'b1);
    send_beat(lfe_pkg::OP_READ,  '0, '0, 1'b0);
  endtask

  // A blinker laid across the column seam on the top row. Its first step
  // turns it upright across the row seam, its second lays it flat again.
  task automatic test_blinker_across_corner();
    send_beat(lfe_pkg::OP_WRITE, lfe_pkg::COL_W'(lfe_pkg::COLS - 1), '0, 1'b1);
    send_beat(lfe_pkg::OP_WRITE, '0, '0, 1'b1);
    send_beat(lfe_pkg::OP_WRITE, lfe_pkg::COL_W'(1), '0, 1'b1);
    send_beat(lfe_pkg::OP_STEP,  '0, lfe_pkg::ROW_W'(lfe_pkg::ROWS - 1), 1'b0);
    send_beat(lfe_pkg::OP_READ,  lfe_pkg::COL_W'(lfe_pkg::COLS - 1), '0, 1'b0);
    send_beat(lfe_pkg::OP_READ,  '0, lfe_pkg::ROW_W'(1), 1'b0);
    send_beat(lfe_pkg::OP_STEP,  lfe_pkg::COL_W'(lfe_pkg::COLS - 1), '0, 1'b1);
    send_beat(lfe_pkg::OP_READ,  '0, lfe_pkg::ROW_W'(lfe_pkg::ROWS - 1), 1'b0);
  endtask

  // Seeds a small colony in a window that may straddle the seams, then lets
  // it evolve for a few generations with reads in between.
  task automatic run_colony();
    int unsigned oc, orw, w, h, seeds, steps, reads;
    if ($urandom_range(0, 1) == 1) begin
      send_beat(lfe_pkg::OP_CLEAR, rand_col(), rand_row(), rand_bit());
    end
    oc  = $urandom_range(0, lfe_pkg::COLS - 1);
    orw = $urandom_range(0, lfe_pkg::ROWS - 1);
    if ($urandom_range(0, 9) == 0) begin
      w = lfe_pkg::COLS;
      h = lfe_pkg::ROWS;
    end else begin
      w = $urandom_range(3, 10);
      h = $urandom_range(3, 10);
    end
    seeds = $urandom_range(4, 24);
    repeat (seeds) begin
      send_beat(lfe_pkg::OP_WRITE,
                lfe_pkg::COL_W'(wrap_pick(oc, w, lfe_pkg::COLS)),
                lfe_pkg::ROW_W'(wrap_pick(orw, h, lfe_pkg::ROWS)),
                $urandom_range(0, 3) != 0);
    end
    steps = $urandom_range(1, 5);
    repeat (steps) begin
      send_beat(lfe_pkg::OP_STEP,
                lfe_pkg::COL_W'(wrap_pick(oc, w, lfe_pkg::COLS)),
                lfe_pkg::ROW_W'(wrap_pick(orw, h, lfe_pkg::ROWS)),
                rand_bit());
      reads = $urandom_range(0, 3);
      repeat (reads) begin
        send_beat(lfe_pkg::OP_READ,
                  lfe_pkg::COL_W'(wrap_pick(oc, w, lfe_pkg::COLS)),
                  lfe_pkg::ROW_W'(wrap_pick(orw, h, lfe_pkg::ROWS)),
                  rand_bit());
      end
    end
  endtask

  // Mostly colonies, with bursts of fully random commands as noise. Idle gaps
  // come and go per episode and stop for the final stretch.
  task automatic test_random_colonies(input int unsigned beat_target);
    int unsigned noise;
    while (beats_sent < beat_target) begin
      idle_on = (beats_sent + CALM_TAIL < beat_target) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        run_colony();
      end else begin
        noise = $urandom_range(5, 20);
        repeat (noise) begin
          send_beat(2'($urandom_range(0, 3)), rand_col(), rand_row(), rand_bit());
        end
      end
    end
    idle_on = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_write_read_extremes();
    test_clear();
    test_blinker_across_corner();
    test_random_colonies(beats_sent + RANDOM_BEATS);

    // The last send returned at its accepting edge without touching start.
    start <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk);
    // Any stray strobe after the last expected beat is caught by the monitor.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("life_automaton_torus_step_top_tb OK");
    end else begin
      $display("life_automaton_torus_step_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("life_automaton_torus_step_top_tb NOT OK");
    $finish;
  end

endmodule
